// File: design/tbs_pkg.sv
// Package for the triangular back-substitution solver.
// Shared types, constants, state encoding and a saturation function; no dependencies.
`default_nettype none
package tbs_pkg;
    localparam int unsigned MaxUnknowns = 16;
    localparam int unsigned IdxW = 4;

    typedef logic [1:0] t_mode;
    localparam t_mode ModeLoadCoef = 2'd0;
    localparam t_mode ModeLoadRhs  = 2'd1;
    localparam t_mode ModeSolve    = 2'd2;

    typedef struct packed {
        t_mode             mode;
        logic [IdxW-1:0]   row;
        logic [IdxW-1:0]   column;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0]    unknown_index;
        logic signed [31:0] solution_value;
        logic               zero_pivot;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_RD, S_MUL, S_SUB, S_DIV, S_DIVRUN, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -65'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// File: design/tbs_if.sv
// Valid/ready channel interface carrying one payload item.
// Payload type is a parameter so both channels share this file.
`default_nettype none
interface tbs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/tbs_divider.sv
// Restoring signed divider, one quotient bit per cycle, with Q16.16 saturation.
// Depends on tbs_pkg.
`default_nettype none
module tbs_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    import tbs_pkg::*;
    logic [47:0] r_rem_n, n_rem_n;   // dividend magnitude shifting out
    logic [32:0] r_part, n_part;
    logic [47:0] r_q, n_q;
    logic [31:0] r_dmag;
    logic        r_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy;
    logic [32:0] w_trial;
    logic [48:0] w_sq;

    always_comb begin
        n_part = {r_part[31:0], r_rem_n[47]};
        w_trial = n_part - {1'b0, r_dmag};
        n_q = {r_q[46:0], ~w_trial[32]};
        if (!w_trial[32]) n_part = w_trial;
        n_rem_n = {r_rem_n[46:0], 1'b0};
        n_cnt = r_cnt - 6'd1;
        w_sq = r_neg ? -{1'b0, n_q} : {1'b0, n_q};
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_cnt   <= 6'd48;
            r_part  <= '0;
            r_q     <= '0;
            r_neg   <= i_num[31] ^ i_den[31];
            r_dmag  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_rem_n <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
        end else if (r_busy) begin
            r_part  <= n_part;
            r_q     <= n_q;
            r_rem_n <= n_rem_n;
            r_cnt   <= n_cnt;
            if (n_cnt == 6'd0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
                o_quot <= sat32(65'(signed'(w_sq)));
            end
        end
    end
endmodule
`default_nettype wire

// File: design/triangular_back_substitution.sv
// Top level of the back-substitution solver.
// Depends on tbs_pkg, tbs_if and tbs_divider.
//
// Usage: input items arrive on s_in (valid/ready). Mode 0 loads A[row][column],
// mode 1 loads b[row], mode 2 starts a solve of the leading size_in_use rows.
// Loads are accepted back to back. A solve walks rows from last to first.
// Per row: fetch diagonal and rhs, then read, multiply and subtract for each
// product term, launch the divide, run the bit-serial division, then the
// output state (transfer and write-back of the unknown). A zero diagonal
// skips the division. Input is not ready while a solve runs.
// Results leave through an output register; while the receiver stalls, the
// solver holds in its output state and takes no new item. Reset clears
// control state and sets size_in_use to 16; the stores stay undefined
// until written. Configuration is written through i_cfg_we/i_cfg_data.
`default_nettype none
module triangular_back_substitution (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data,
    tbs_if.sink             s_in,
    tbs_if.source           m_out
);
    import tbs_pkg::*;

    logic signed [31:0] r_coef [MaxUnknowns*MaxUnknowns];
    logic signed [31:0] r_vec  [2*MaxUnknowns];   // rhs low half, solutions high
    logic signed [31:0] r_coef_q, r_vec_q;
    logic [4:0]  r_size;
    t_state      r_state, n_state;
    logic [IdxW-1:0] r_i;
    logic [IdxW:0]   r_j;      // term column, runs up to the row count
    logic [4:0]  r_n;
    logic signed [31:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_diag;
    t_out_item   r_out;
    logic        r_ovalid;
    logic        w_div_done;
    logic signed [31:0] w_quot;
    logic        w_div_start;
    logic [IdxW-1:0] w_ra_j;
    logic        w_rd_vec_sol;
    logic signed [47:0] w_sh;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_in.valid && s_in.data.mode == ModeSolve && r_n != 5'd0)
                n_state = S_ROW;
            S_ROW:    n_state = S_RD;
            S_RD:     n_state = (r_j < r_n) ? S_MUL : S_DIV;
            S_MUL:    n_state = S_SUB;
            S_SUB:    n_state = S_RD;
            S_DIV:    n_state = (r_diag == '0) ? S_OUT : S_DIVRUN;
            S_DIVRUN: if (w_div_done) n_state = S_OUT;
            S_OUT:    if (!r_ovalid) n_state = (r_i == '0) ? S_IDLE : S_ROW;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_in.ready   = (r_state == S_IDLE);
        w_div_start  = (r_state == S_DIV) && (r_diag != '0);
        w_ra_j       = r_j[IdxW-1:0];
        w_rd_vec_sol = (r_state == S_RD);
        w_sh = 48'(r_prod >>> 16);
    end

    always_comb r_n = (r_size > 5'(MaxUnknowns)) ? 5'(MaxUnknowns) : r_size;

    // memories: registered read ports
    // S_ROW reads the diagonal and b[i]; S_RD reads A[i][j] and x[j]
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_in.valid && s_in.data.mode == ModeLoadCoef)
            r_coef[{s_in.data.row, s_in.data.column}] <= s_in.data.value;
        r_coef_q <= r_coef[{r_i, (r_state == S_ROW) ? r_i : w_ra_j}];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_in.valid && s_in.data.mode == ModeLoadRhs)
            r_vec[{1'b0, s_in.data.row}] <= s_in.data.value;
        else if (r_state == S_OUT && !r_ovalid)
            r_vec[{1'b1, r_i}] <= r_out.solution_value;
        r_vec_q <= r_vec[{w_rd_vec_sol, w_rd_vec_sol ? w_ra_j : r_i}];
    end

    tbs_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_acc), .i_den(r_diag), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= 5'd16;
            r_ovalid <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_size <= i_cfg_data;
            // result register: set on entry to S_OUT, cleared by the transfer
            if (n_state == S_OUT && r_state != S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (m_out.valid && m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: r_i <= 4'(r_n - 5'd1);
                S_ROW:  r_j <= {1'b0, r_i} + 5'd1;
                S_RD: begin
                    // first pass after S_ROW: latch diag and rhs
                    if (r_j == {1'b0, r_i} + 5'd1) begin
                        r_diag <= r_coef_q;
                        r_acc  <= r_vec_q;
                    end
                end
                S_MUL: r_prod <= r_coef_q * r_vec_q;
                S_SUB: begin
                    r_acc <= sat32(65'(r_acc) - 65'(sat32(65'(w_sh))));
                    r_j   <= r_j + 5'd1;
                end
                S_DIV: if (r_diag == '0) begin
                    // zero pivot: saturate towards the sign of the running value
                    r_out.solution_value <= r_acc[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    r_out.zero_pivot     <= 1'b1;
                    r_out.unknown_index  <= r_i;
                    r_out.last           <= (r_i == '0);
                end
                S_DIVRUN: if (w_div_done) begin
                    r_out.solution_value <= w_quot;
                    r_out.zero_pivot     <= 1'b0;
                    r_out.unknown_index  <= r_i;
                    r_out.last           <= (r_i == '0);
                end
                S_OUT: if (!r_ovalid) r_i <= r_i - 4'd1;
                default: ;
            endcase
        end
    end

    assign m_out.valid = r_ovalid && r_state == S_OUT;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire
